@@ rtl/core/text_glyph_rasterizer_defines.svh @@
// Assertion macros used by the text glyph rasterizer RTL (the line engine, tgr_back).
// Expects clk and rst_n in the scope where a macro is used.
`ifndef TEXT_GLYPH_RASTERIZER_DEFINES_SVH
`define TEXT_GLYPH_RASTERIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define TGR_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tgr: forbidden condition seen");
`define TGR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgr: same-cycle implication failed");
`define TGR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgr: next-cycle implication failed");
`else
`define TGR_ASSERT_NEVER(lbl, cond)
`define TGR_ASSERT_IMPL(lbl, ante, cons)
`define TGR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/tgr_pkg.sv @@
// Types, codes and the colour palette of the text glyph rasterizer.
// No dependencies; imported by every module of the block.
package tgr_pkg;

    localparam int ADDR_W     = 32;
    localparam int COLOR_W    = 24;
    localparam int SLOT_W     = 12;
    localparam int IDX_W      = 13;
    localparam int STRIDE_W   = 15;
    localparam int BYTES_W    = 3;
    localparam int MODE_W     = 2;
    localparam int WIDTH_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    localparam logic [MODE_W-1:0] MODE_8BPP  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_24BPP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_32BPP = 2'd2;

    localparam logic [BYTES_W-1:0] BYTES_8BPP  = 3'd1;
    localparam logic [BYTES_W-1:0] BYTES_24BPP = 3'd3;
    localparam logic [BYTES_W-1:0] BYTES_32BPP = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE   = 2'd2;

    localparam logic [COLOR_W-1:0] PALETTE [16] = '{
        24'h000000, 24'h800000, 24'h008000, 24'h808000,
        24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0,
        24'h808080, 24'hff0000, 24'h00ff00, 24'hffff00,
        24'h0000ff, 24'hff00ff, 24'h00ffff, 24'hffffff
    };

    typedef struct packed {
        logic              opcode;
        logic [SLOT_W-1:0] font_slot;
        logic [7:0]        font_bits;
        logic [7:0]        char_code;
        logic [3:0]        back_index;
        logic [3:0]        fore_index;
        logic [8:0]        cell_col;
        logic [7:0]        cell_row;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  line_address;
        logic [7:0]         line_pattern;
        logic [COLOR_W-1:0] fore_value;
        logic [COLOR_W-1:0] back_value;
        logic [BYTES_W-1:0] pixel_bytes;
        logic               last_line;
    } out_item_t;

    // One queued command: a font store write or a whole glyph to draw.
    typedef struct packed {
        logic                opcode;
        logic [IDX_W-1:0]    idx;
        logic [7:0]          bits;
        logic [ADDR_W-1:0]   addr;
        logic [STRIDE_W-1:0] stride;
        logic [COLOR_W-1:0]  fore;
        logic [COLOR_W-1:0]  back;
        logic [BYTES_W-1:0]  nbytes;
    } cmd_t;

    function automatic logic [COLOR_W-1:0] pixel_value(input logic [MODE_W-1:0] mode,
                                                       input logic [3:0] cidx);
        logic [COLOR_W-1:0] v;
        if (mode == MODE_8BPP)
            v = COLOR_W'(cidx);
        else
            v = PALETTE[cidx];
        return v;
    endfunction

    function automatic logic [BYTES_W-1:0] bytes_per_pixel(input logic [MODE_W-1:0] mode);
        logic [BYTES_W-1:0] b;
        case (mode)
            MODE_8BPP:  b = BYTES_8BPP;
            MODE_24BPP: b = BYTES_24BPP;
            default:    b = BYTES_32BPP;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/tgr_front.sv @@
// Front end: accepts items, resolves colours and computes the glyph's first line address.
// Depends on tgr_pkg; feeds commands to tgr_queue.
module tgr_front #(
    parameter int GLYPH_LINES = 16,
    parameter int CHAR_COUNT  = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  tgr_pkg::in_item_t                    in_data,
    input  logic [tgr_pkg::ADDR_W-1:0]           frame_base,
    input  logic [tgr_pkg::WIDTH_W-1:0]          screen_width,
    input  logic [tgr_pkg::MODE_W-1:0]           pixel_mode,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output tgr_pkg::cmd_t                        push_data
);
    import tgr_pkg::*;

    localparam int FONT_DEPTH = CHAR_COUNT * GLYPH_LINES;
    localparam int LINE_W     = $clog2(GLYPH_LINES);
    localparam int Y_W        = 8 + LINE_W;
    localparam int PROD_W     = WIDTH_W + Y_W;
    localparam int OFFS_W     = PROD_W + 1;

    typedef enum logic [4:0] {
        F_IDLE  = 5'b00001,
        F_MUL   = 5'b00010,
        F_SUM   = 5'b00100,
        F_SCALE = 5'b01000,
        F_PUSH  = 5'b10000
    } front_state_t;

    front_state_t        state_reg, state_next;
    in_item_t            item_reg;
    logic [IDX_W-1:0]    glyph_reg;
    logic [Y_W-1:0]      y0_reg;
    logic [COLOR_W-1:0]  fore_reg, back_reg;
    logic [BYTES_W-1:0]  bytes_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [OFFS_W-1:0]   offs_reg;
    logic [ADDR_W-1:0]   scaled_reg;

    logic                accept;
    logic                slot_ok;
    logic [8:0]          code_wide;
    logic [7:0]          code_mod;
    logic [BYTES_W-1:0]  in_bytes;

    function automatic logic [ADDR_W-1:0] scale_bytes(input logic [BYTES_W-1:0] nb,
                                                      input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] r;
        case (nb)
            BYTES_8BPP:  r = v;
            BYTES_24BPP: r = v + (v << 1);
            default:     r = v << 2;
        endcase
        return r;
    endfunction

    assign in_ready = (state_reg == F_IDLE);
    assign accept   = in_valid && in_ready;
    assign slot_ok  = (14'(in_data.font_slot) < 14'(FONT_DEPTH));
    assign in_bytes = bytes_per_pixel(pixel_mode);

    // Character code wraps once at most; that covers every 8-bit code only while CHAR_COUNT is 128 or more.
    assign code_wide = {1'b0, in_data.char_code};
    assign code_mod  = (code_wide >= 9'(CHAR_COUNT)) ? 8'(code_wide - 9'(CHAR_COUNT))
                                                     : in_data.char_code;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.opcode == OP_DRAW)
                        state_next = F_MUL;
                    else if (slot_ok)
                        state_next = F_PUSH;
                end
            end
            F_MUL:   state_next = F_SUM;
            F_SUM:   state_next = F_SCALE;
            F_SCALE: state_next = F_PUSH;
            F_PUSH:
            begin
                if (push_ready)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= in_data;
            glyph_reg  <= IDX_W'(code_mod) * IDX_W'(GLYPH_LINES);
            y0_reg     <= Y_W'(in_data.cell_row) * Y_W'(GLYPH_LINES);
            fore_reg   <= pixel_value(pixel_mode, in_data.fore_index);
            back_reg   <= pixel_value(pixel_mode, in_data.back_index);
            bytes_reg  <= in_bytes;
            stride_reg <= STRIDE_W'(scale_bytes(in_bytes, ADDR_W'(screen_width)));
        end
        if (state_reg == F_MUL)
            prod_reg <= PROD_W'(screen_width) * PROD_W'(y0_reg);
        if (state_reg == F_SUM)
            offs_reg <= OFFS_W'(prod_reg) + OFFS_W'({item_reg.cell_col, 3'b000});
        if (state_reg == F_SCALE)
            scaled_reg <= scale_bytes(bytes_reg, ADDR_W'(offs_reg));
    end

    assign push_valid = (state_reg == F_PUSH);

    always_comb
    begin
        push_data.opcode = item_reg.opcode;
        push_data.idx    = (item_reg.opcode == OP_DRAW) ? glyph_reg
                                                        : IDX_W'(item_reg.font_slot);
        push_data.bits   = item_reg.font_bits;
        push_data.addr   = frame_base + scaled_reg;
        push_data.stride = stride_reg;
        push_data.fore   = fore_reg;
        push_data.back   = back_reg;
        push_data.nbytes = bytes_reg;
    end

endmodule

@@ rtl/core/tgr_queue.sv @@
// Short command queue between the front end and the line engine.
// Depends on tgr_pkg.
module tgr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  tgr_pkg::cmd_t push_data,
    output logic          head_valid,
    input  logic          pop,
    output tgr_pkg::cmd_t head
);
    import tgr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ rtl/core/tgr_back.sv @@
// Line engine: owns the font store, writes loads and walks glyph lines one per cycle while the output is not stalled.
// Depends on tgr_pkg and text_glyph_rasterizer_defines.svh.
`include "text_glyph_rasterizer_defines.svh"

module tgr_back #(
    parameter int GLYPH_LINES = 16,
    parameter int CHAR_COUNT  = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  tgr_pkg::cmd_t     head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output tgr_pkg::out_item_t out_data
);
    import tgr_pkg::*;

    localparam int FONT_DEPTH = CHAR_COUNT * GLYPH_LINES;
    localparam int MEM_AW     = $clog2(FONT_DEPTH);
    localparam int LINE_W     = $clog2(GLYPH_LINES);
    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(GLYPH_LINES - 1);

    logic [7:0]          font_mem [FONT_DEPTH];
    logic [7:0]          rd_data_reg;
    logic [LINE_W-1:0]   line_reg;
    logic [ADDR_W-1:0]   addr_reg;

    logic                r_valid_reg;
    logic [ADDR_W-1:0]   r_addr_reg;
    logic                r_last_reg;
    logic [COLOR_W-1:0]  r_fore_reg, r_back_reg;
    logic [BYTES_W-1:0]  r_bytes_reg;

    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic                o_load, r_move, r_free;
    logic                is_load, is_draw, issue, line_last;
    logic [ADDR_W-1:0]   issue_addr;
    logic [MEM_AW-1:0]   rd_addr;

    assign o_load     = !out_valid_reg || out_ready;
    assign r_move     = r_valid_reg && o_load;
    assign r_free     = !r_valid_reg || o_load;
    assign is_load    = head_valid && (head.opcode == OP_LOAD);
    assign is_draw    = head_valid && (head.opcode == OP_DRAW);
    assign issue      = is_draw && r_free;
    assign line_last  = (line_reg == LAST_LINE);
    assign issue_addr = (line_reg == '0) ? head.addr : addr_reg;
    assign rd_addr    = MEM_AW'(head.idx + IDX_W'(line_reg));
    assign pop        = is_load || (issue && line_last);

    always_ff @(posedge clk)
    begin
        if (is_load)
            font_mem[MEM_AW'(head.idx)] <= head.bits;
        if (issue)
            rd_data_reg <= font_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg      <= '0;
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
                line_reg <= line_last ? '0 : line_reg + 1'b1;
            if (r_free)
                r_valid_reg <= issue;
            if (o_load)
                out_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            addr_reg    <= issue_addr + ADDR_W'(head.stride);
            r_addr_reg  <= issue_addr;
            r_last_reg  <= line_last;
            r_fore_reg  <= head.fore;
            r_back_reg  <= head.back;
            r_bytes_reg <= head.nbytes;
        end
        if (r_move)
        begin
            out_data_reg.line_address <= r_addr_reg;
            out_data_reg.line_pattern <= rd_data_reg;
            out_data_reg.fore_value   <= r_fore_reg;
            out_data_reg.back_value   <= r_back_reg;
            out_data_reg.pixel_bytes  <= r_bytes_reg;
            out_data_reg.last_line    <= r_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `TGR_ASSERT_NEVER(a_load_during_issue, is_load && issue)
    `TGR_ASSERT_IMPL(a_pop_after_last_line, issue && line_last, pop)
    `TGR_ASSERT_NEXT(a_line_wraps, issue && line_last, line_reg == '0)

endmodule

@@ rtl/core/text_glyph_rasterizer.sv @@
// Top level of the 8-pixel-wide bitmap font character generator.
// Depends on tgr_pkg, tgr_front, tgr_queue and tgr_back.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | input     | in_valid / in_ready   | in_data  (load byte or draw glyph)
//  out     | output    | out_valid / out_ready | out_data (one glyph scan line)
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// A draw item yields GLYPH_LINES results, one per cycle while out_ready stays high;
// the line engine's single font store read port sets that pace, also for a steady
// stream of draws. A load item passes the front end's idle and push states and is
// written to the font store as the line engine pops it. The front end forms the
// start address in its multiply, sum and scale states and works ahead of the
// engine through a two-entry command queue. Reset clears control state only; the
// font store is undefined until loaded. A stalled out channel holds the result
// register and backs up into the queue and then the in channel.
module text_glyph_rasterizer #(
    parameter int GLYPH_LINES = 16,
    parameter int CHAR_COUNT  = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  tgr_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output tgr_pkg::out_item_t              out_data,
    input  logic                            cfg_we,
    input  logic [tgr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tgr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tgr_pkg::*;

    // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
    logic [ADDR_W-1:0]  frame_base_reg;
    logic [WIDTH_W-1:0] screen_width_reg;
    logic [MODE_W-1:0]  pixel_mode_reg;

    // Front end to queue, queue to line engine.
    logic               push_valid, push_ready;
    cmd_t               push_data;
    logic               head_valid, pop;
    cmd_t               head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg   <= '0;
            screen_width_reg <= WIDTH_W'(640);
            pixel_mode_reg   <= MODE_32BPP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_BASE:   frame_base_reg   <= cfg_data[ADDR_W-1:0];
                REG_SCREEN_WIDTH: screen_width_reg <= cfg_data[WIDTH_W-1:0];
                REG_PIXEL_MODE:   pixel_mode_reg   <= cfg_data[MODE_W-1:0];
                default:          ; // drop writes to unmapped indexes
            endcase
        end
    end

    // Classify items, resolve colours, compute the top line's byte address.
    tgr_front #(
        .GLYPH_LINES (GLYPH_LINES),
        .CHAR_COUNT  (CHAR_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .frame_base   (frame_base_reg),
        .screen_width (screen_width_reg),
        .pixel_mode   (pixel_mode_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    // Hold commands so the front end keeps accepting while a glyph is drawn.
    tgr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .head_valid (head_valid),
        .pop        (pop),
        .head       (head)
    );

    // Write font bytes and emit one scan line per cycle while out_ready is high, advancing by the stride.
    tgr_back #(
        .GLYPH_LINES (GLYPH_LINES),
        .CHAR_COUNT  (CHAR_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

@@ verif/tb_text_glyph_rasterizer.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the text glyph rasterizer (8x16 bitmap character generator).
// Depends on tgr_pkg and the text_glyph_rasterizer RTL; keeps its own font and register mirror.
module tb_text_glyph_rasterizer;
    import tgr_pkg::*;

    localparam int GLYPH_LINES   = 16;
    localparam int CHAR_COUNT    = 256;
    localparam int FONT_DEPTH    = GLYPH_LINES * CHAR_COUNT;
    localparam int ITEM_TARGET   = 410;
    // Loads leave no result behind, so give the front end and queue time to empty.
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;

    // The package names three pixel modes; the fourth encoding behaves as 32 bpp.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    text_glyph_rasterizer #(
        .GLYPH_LINES(GLYPH_LINES),
        .CHAR_COUNT (CHAR_COUNT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Mirror of the font store and of the three registers.
    logic [7:0]         font_copy [FONT_DEPTH];
    bit                 slot_loaded [FONT_DEPTH];
    bit                 glyph_listed [CHAR_COUNT];
    logic [7:0]         drawable [$];
    logic [ADDR_W-1:0]  base_mirror;
    logic [WIDTH_W-1:0] width_mirror;
    logic [MODE_W-1:0]  mode_mirror;

    // Glyph lines still owed by the block, oldest first.
    out_item_t lines_due [$];
    out_item_t line_want;

    int mismatches = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int out_hold_request = 0;
    bit in_steady = 1'b0;
    bit out_steady = 1'b0;

    // ------------------------------------------------------------------
    // Prediction: apply one accepted item to the mirror; a draw queues
    // sixteen expected glyph lines, top line first.
    // ------------------------------------------------------------------
    function automatic void apply_item(input in_item_t it);
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        logic [BYTES_W-1:0] nbytes;
        logic [ADDR_W-1:0]  x;
        logic [ADDR_W-1:0]  y;
        logic [7:0]         code;
        out_item_t          line;
        bit                 full;
        int                 l;

        if (it.opcode == OP_LOAD)
        begin
            font_copy[it.font_slot] = it.font_bits;
            slot_loaded[it.font_slot] = 1'b1;
            // Make the character drawable once all of its lines hold data.
            code = it.font_slot[11:4];
            full = 1'b1;
            for (l = 0; l < GLYPH_LINES; l++)
                full &= slot_loaded[{code, 4'(l)}];
            if (full && !glyph_listed[code])
            begin
                glyph_listed[code] = 1'b1;
                drawable.push_back(code);
            end
            return;
        end

        code = it.char_code;
        if (mode_mirror == MODE_8BPP)
        begin
            fore = {20'd0, it.fore_index};
            back = {20'd0, it.back_index};
        end
        else
        begin
            fore = PALETTE[it.fore_index];
            back = PALETTE[it.back_index];
        end
        if (mode_mirror == MODE_8BPP)
            nbytes = BYTES_8BPP;
        else if (mode_mirror == MODE_24BPP)
            nbytes = BYTES_24BPP;
        else
            nbytes = BYTES_32BPP;

        x = {20'd0, it.cell_col, 3'd0};
        for (l = 0; l < GLYPH_LINES; l++)
        begin
            y = {20'd0, it.cell_row, 4'(l)};
            line.line_address = base_mirror
                              + {29'd0, nbytes} * ({19'd0, width_mirror} * y + x);
            line.line_pattern = font_copy[{code, 4'(l)}];
            line.fore_value   = fore;
            line.back_value   = back;
            line.pixel_bytes  = nbytes;
            line.last_line    = (l == GLYPH_LINES - 1);
            lines_due.push_back(line);
        end
    endfunction

    // ------------------------------------------------------------------
    // Item builders: fields the opcode ignores still get random bits.
    // ------------------------------------------------------------------
    function automatic in_item_t any_item();
        in_item_t it;
        it.opcode     = 1'($urandom_range(0, 1));
        it.font_slot  = 12'($urandom);
        it.font_bits  = 8'($urandom);
        it.char_code  = 8'($urandom);
        it.back_index = 4'($urandom);
        it.fore_index = 4'($urandom);
        it.cell_col   = 9'($urandom);
        it.cell_row   = 8'($urandom);
        return it;
    endfunction

    function automatic in_item_t load_item(input logic [SLOT_W-1:0] slot,
                                           input logic [7:0] bits);
        in_item_t it;
        it           = any_item();
        it.opcode    = OP_LOAD;
        it.font_slot = slot;
        it.font_bits = bits;
        return it;
    endfunction

    function automatic in_item_t draw_item(input logic [7:0] code, input logic [3:0] fore,
                                           input logic [3:0] back, input logic [8:0] col,
                                           input logic [7:0] row);
        in_item_t it;
        it            = any_item();
        it.opcode     = OP_DRAW;
        it.char_code  = code;
        it.fore_index = fore;
        it.back_index = back;
        it.cell_col   = col;
        it.cell_row   = row;
        return it;
    endfunction

    // Glyph line data, leaning on blank and solid lines now and then.
    function automatic logic [7:0] glyph_bits();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'hff;
            default: b = 8'($urandom);
        endcase
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Sender: hold off a random number of cycles, then hold valid and the
    // item steady until the handshake; predict on acceptance.
    // ------------------------------------------------------------------
    task automatic send_item(input in_item_t it);
        int gap;
        gap = in_steady ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        apply_item(it);
        items_sent++;
    endtask

    // Drop valid, wait for every owed line, then let in-flight loads finish.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (lines_due.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One register write; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_FRAME_BASE:   base_mirror  = data;
            REG_SCREEN_WIDTH: width_mirror = data[WIDTH_W-1:0];
            REG_PIXEL_MODE:   mode_mirror  = data[MODE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_glyph(input logic [7:0] code);
        int l;
        for (l = 0; l < GLYPH_LINES; l++)
            send_item(load_item({code, 4'(l)}, glyph_bits()));
    endtask

    task automatic random_draw(input logic [7:0] code);
        send_item(draw_item(code, 4'($urandom), 4'($urandom), 9'($urandom), 8'($urandom)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Load the last character with edge patterns and draw it in both
    // corner cells under the reset register values.
    task automatic test_reset_defaults();
        logic [7:0] rows [GLYPH_LINES];
        int l;
        rows = '{8'h00, 8'hff, 8'h80, 8'h01, 8'h55, 8'haa, 8'h18, 8'h3c,
                 8'h7e, 8'he7, 8'hc3, 8'h81, 8'h42, 8'h24, 8'h0f, 8'hf0};
        for (l = 0; l < GLYPH_LINES; l++)
            send_item(load_item({8'hff, 4'(l)}, rows[l]));
        send_item(draw_item(8'hff, 4'hf, 4'h0, 9'd0, 8'd0));
        send_item(draw_item(8'hff, 4'h0, 4'hf, 9'd511, 8'd255));
    endtask

    // Walk every pixel mode, including the spare encoding, with extreme
    // bases and strides: address wrap, narrowest and widest lines, zero and
    // odd strides.
    task automatic test_pixel_modes();
        wait_drained();
        write_reg(REG_PIXEL_MODE, 32'(MODE_8BPP));
        write_reg(REG_FRAME_BASE, 32'hffff_ffff);
        write_reg(REG_SCREEN_WIDTH, 32'd4096);
        send_item(draw_item(8'hff, 4'h9, 4'h6, 9'd511, 8'd255));

        wait_drained();
        write_reg(REG_PIXEL_MODE, 32'(MODE_24BPP));
        write_reg(REG_FRAME_BASE, 32'h8000_0000);
        write_reg(REG_SCREEN_WIDTH, 32'd8);
        send_item(draw_item(8'hff, 4'h7, 4'h8, 9'd1, 8'd1));

        wait_drained();
        write_reg(REG_PIXEL_MODE, 32'(MODE_SPARE));
        write_reg(REG_FRAME_BASE, $urandom);
        write_reg(REG_SCREEN_WIDTH, 32'h1fff);
        send_item(draw_item(8'hff, 4'h1, 4'h2, 9'd300, 8'd128));

        wait_drained();
        write_reg(REG_PIXEL_MODE, 32'(MODE_32BPP));
        write_reg(REG_FRAME_BASE, 32'h0);
        write_reg(REG_SCREEN_WIDTH, 32'd0);
        send_item(draw_item(8'hff, 4'hc, 4'h3, 9'd17, 8'd200));

        wait_drained();
        write_reg(REG_SCREEN_WIDTH, 32'd641);
        send_item(draw_item(8'hff, 4'h5, 4'ha, 9'd256, 8'd127));
    endtask

    // Stall the result side for a long stretch while draws keep coming, so
    // the queue fills and in_ready drops; then pause until all lines are in.
    task automatic test_back_pressure();
        int n;
        wait_drained();
        in_steady = 1'b1;
        out_hold_request = LONG_HOLD;
        for (n = 0; n < 12; n++)
            random_draw(drawable[$urandom_range(0, drawable.size() - 1)]);
        in_steady = 1'b0;
        wait_drained();
    endtask

    // Mixed traffic in several register settings: mostly whole glyph loads
    // followed by draws of loaded characters, plus stray single-byte loads.
    task automatic test_random_traffic();
        int phase;
        int target;
        logic [7:0] code;
        logic [CFG_DATA_W-1:0] value;

        for (phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            case ($urandom_range(0, 3))
                0:       value = 32'h0;
                1:       value = 32'hffff_ffff;
                default: value = $urandom;
            endcase
            write_reg(REG_FRAME_BASE, value);
            case ($urandom_range(0, 3))
                0:       value = 32'd8;
                1:       value = 32'd4096;
                2:       value = 32'($urandom_range(0, 8191));
                default: value = 32'($urandom_range(8, 4096));
            endcase
            write_reg(REG_SCREEN_WIDTH, value);
            write_reg(REG_PIXEL_MODE, 32'($urandom_range(0, 3)));

            // First phase runs with no idling on either side.
            in_steady  = (phase == 0);
            out_steady = (phase == 0);
            if (phase == 0)
            begin
                load_glyph(8'h00);
                random_draw(8'h00);
            end
            target = (phase == 3) ? ITEM_TARGET
                                  : items_sent + (ITEM_TARGET - items_sent) / (4 - phase);
            while (items_sent < target)
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        code = 8'($urandom);
                        load_glyph(code);
                        random_draw(code);
                    end
                    8, 9: send_item(load_item(12'($urandom), glyph_bits()));
                    default: random_draw(drawable[$urandom_range(0, drawable.size() - 1)]);
                endcase
            end
        end
        in_steady  = 1'b0;
        out_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: idle a random number of cycles before each line, honor a
    // long hold when a test asks for one, then take the next line.
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (out_hold_request > 0)
            begin
                out_ready <= 1'b0;
                repeat (out_hold_request) @(negedge clk);
                out_hold_request = 0;
            end
            gap = out_steady ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Compare every accepted line with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (lines_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected glyph line addr %h bits %h", $realtime,
                             out_data.line_address, out_data.line_pattern);
            end
            else
            begin
                line_want = lines_due.pop_front();
                if (out_data.line_address !== line_want.line_address
                    || out_data.line_pattern !== line_want.line_pattern
                    || out_data.fore_value !== line_want.fore_value
                    || out_data.back_value !== line_want.back_value
                    || out_data.pixel_bytes !== line_want.pixel_bytes
                    || out_data.last_line !== line_want.last_line)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("%0t: glyph line mismatch", $realtime);
                        $display("  expected addr %h bits %h fg %h bg %h bytes %0d last %0b",
                                 line_want.line_address, line_want.line_pattern,
                                 line_want.fore_value, line_want.back_value,
                                 line_want.pixel_bytes, line_want.last_line);
                        $display("  got      addr %h bits %h fg %h bg %h bytes %0d last %0b",
                                 out_data.line_address, out_data.line_pattern,
                                 out_data.fore_value, out_data.back_value,
                                 out_data.pixel_bytes, out_data.last_line);
                    end
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        base_mirror  = '0;
        width_mirror = 13'd640;
        mode_mirror  = MODE_32BPP;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_pixel_modes();
        test_back_pressure();
        test_random_traffic();
        wait_drained();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tgr_pkg.sv
rtl/core/tgr_front.sv
rtl/core/tgr_queue.sv
rtl/core/tgr_back.sv
rtl/core/text_glyph_rasterizer.sv
verif/tb_text_glyph_rasterizer.sv
